// ----- hdl/kwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table package
// Sizes, request and status codes, and sequencer states of the key/value table.
// ----------------------------------------------------------------------------
package kwc_pkg;

  localparam int CAPACITY   = 32;
  localparam int NAME_BYTES = 8;

  localparam int DATA_W  = 64;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 6;
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * NAME_BYTES);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DELETED  = 3'd3,
    ST_FULL     = 3'd4,
    ST_LISTED   = 3'd5,
    ST_TOTAL    = 3'd6
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN      = 7'b0000010,
    S_DEL_RD    = 7'b0000100,
    S_DEL_WR    = 7'b0001000,
    S_LIST_RD   = 7'b0010000,
    S_LIST_DAT  = 7'b0100000,
    S_LIST_WAIT = 7'b1000000
  } state_e;

endpackage

// ----- hdl/kwc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/keyed_table_with_compaction_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table with compaction
// Linear-search key/value table with add, find, delete and list requests.
// ----------------------------------------------------------------------------
// A request enters on the in channel (req_type_i, key_i, value_i) under
// valid/ready; results leave on the out channel from one output register.
// The block takes one request at a time: in_ready_o is high only while the
// sequencer is idle and the output register is empty.
// An add writes the RAMs and registers its result, which shows the cycle after the request.
// Find and delete scan the table through one shared key comparator fed by the
// key RAM's single read port, one entry per cycle behind the registered read
// data; a scan ends at the first match or after the last entry, and a delete
// that hits then reads the last entry and copies it into the freed slot.
// List reads one entry per result, registers it and waits until the receiver
// takes it before the next read, then gives the total; last_o marks the final
// result of every request.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties the table at once by clearing the entry count; the RAMs are
// not cleared, since entries beyond the count are never read.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kwc_pkg::REQ_W-1:0]   req_type_i,
  input  logic [kwc_pkg::DATA_W-1:0]  key_i,
  input  logic [kwc_pkg::DATA_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kwc_pkg::STAT_W-1:0]  status_o,
  output logic [kwc_pkg::DATA_W-1:0]  out_key_o,
  output logic [kwc_pkg::DATA_W-1:0]  out_value_o,
  output logic [kwc_pkg::TOTAL_W-1:0] entry_total_o,
  output logic                        last_o
);

  kwc_pkg::state_e state_q, state_d;

  logic [kwc_pkg::CNT_W-1:0]  count_q, count_d;
  logic [kwc_pkg::CNT_W-1:0]  iss_q, iss_d;
  logic [kwc_pkg::ADDR_W-1:0] chk_idx_q, chk_idx_d;
  logic                       chk_q, chk_d;
  logic [kwc_pkg::ADDR_W-1:0] hit_q, hit_d;
  logic [kwc_pkg::DATA_W-1:0] key_q, key_d;
  kwc_pkg::req_e              req_q, req_d;

  logic                        out_valid_q, out_valid_d;
  logic [kwc_pkg::STAT_W-1:0]  status_q, status_d;
  logic [kwc_pkg::DATA_W-1:0]  out_key_q, out_key_d;
  logic [kwc_pkg::DATA_W-1:0]  out_value_q, out_value_d;
  logic [kwc_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                        last_q, last_d;

  logic                        ram_we;
  logic [kwc_pkg::ADDR_W-1:0]  ram_waddr;
  logic [kwc_pkg::DATA_W-1:0]  ram_wkey;
  logic [kwc_pkg::DATA_W-1:0]  ram_wval;
  logic                        ram_re;
  logic [kwc_pkg::ADDR_W-1:0]  ram_raddr;
  logic [kwc_pkg::DATA_W-1:0]  key_rd;
  logic [kwc_pkg::DATA_W-1:0]  val_rd;

  logic in_fire;
  logic key_match;
  logic [kwc_pkg::CNT_W-1:0] last_ix;

  assign in_ready_o = (state_q == kwc_pkg::S_IDLE) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign key_match  = chk_q && (key_rd == key_q);
  assign last_ix    = count_q - kwc_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    chk_idx_d   = chk_idx_q;
    chk_d       = 1'b0;
    hit_d       = hit_q;
    key_d       = key_q;
    req_d       = req_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_key_d   = out_key_q;
    out_value_d = out_value_q;
    total_d     = total_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[kwc_pkg::ADDR_W-1:0];
    ram_wkey    = key_i & kwc_pkg::KEY_MASK;
    ram_wval    = value_i;
    ram_re      = 1'b0;
    ram_raddr   = iss_q[kwc_pkg::ADDR_W-1:0];

    case (state_q)
      kwc_pkg::S_IDLE: begin
        if (in_fire) begin
          key_d = key_i & kwc_pkg::KEY_MASK;
          req_d = kwc_pkg::req_e'(req_type_i);
          iss_d = '0;
          case (kwc_pkg::req_e'(req_type_i))
            kwc_pkg::REQ_ADD: begin
              out_valid_d = 1'b1;
              out_key_d   = '0;
              out_value_d = '0;
              last_d      = 1'b1;
              if (count_q >= kwc_pkg::CNT_W'(kwc_pkg::CAPACITY)) begin
                status_d = kwc_pkg::ST_FULL;
                total_d  = kwc_pkg::TOTAL_W'(count_q);
              end else begin
                ram_we   = 1'b1;
                count_d  = count_q + kwc_pkg::CNT_W'(1);
                status_d = kwc_pkg::ST_ADDED;
                total_d  = kwc_pkg::TOTAL_W'(count_q + kwc_pkg::CNT_W'(1));
              end
            end
            kwc_pkg::REQ_LIST: state_d = kwc_pkg::S_LIST_RD;
            default:           state_d = kwc_pkg::S_SCAN;
          endcase
        end
      end

      kwc_pkg::S_SCAN: begin
        if (key_match) begin
          hit_d = chk_idx_q;
          if (req_q == kwc_pkg::REQ_DELETE) begin
            state_d = kwc_pkg::S_DEL_RD;
          end else begin
            out_valid_d = 1'b1;
            status_d    = kwc_pkg::ST_FOUND;
            out_key_d   = '0;
            out_value_d = val_rd;
            total_d     = kwc_pkg::TOTAL_W'(count_q);
            last_d      = 1'b1;
            state_d     = kwc_pkg::S_IDLE;
          end
        end else if (iss_q < count_q) begin
          // Issue the next read while the previous entry is being compared.
          ram_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = iss_q[kwc_pkg::ADDR_W-1:0];
          iss_d     = iss_q + kwc_pkg::CNT_W'(1);
        end else begin
          out_valid_d = 1'b1;
          status_d    = kwc_pkg::ST_NOTFOUND;
          out_key_d   = '0;
          out_value_d = '0;
          total_d     = kwc_pkg::TOTAL_W'(count_q);
          last_d      = 1'b1;
          state_d     = kwc_pkg::S_IDLE;
        end
      end

      kwc_pkg::S_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = last_ix[kwc_pkg::ADDR_W-1:0];
        state_d   = kwc_pkg::S_DEL_WR;
      end

      kwc_pkg::S_DEL_WR: begin
        // Move the last entry into the freed slot; a self-copy when they match.
        ram_we      = 1'b1;
        ram_waddr   = hit_q;
        ram_wkey    = key_rd;
        ram_wval    = val_rd;
        count_d     = last_ix;
        out_valid_d = 1'b1;
        status_d    = kwc_pkg::ST_DELETED;
        out_key_d   = '0;
        out_value_d = '0;
        total_d     = kwc_pkg::TOTAL_W'(last_ix);
        last_d      = 1'b1;
        state_d     = kwc_pkg::S_IDLE;
      end

      kwc_pkg::S_LIST_RD: begin
        if (iss_q < count_q) begin
          ram_re  = 1'b1;
          iss_d   = iss_q + kwc_pkg::CNT_W'(1);
          state_d = kwc_pkg::S_LIST_DAT;
        end else begin
          out_valid_d = 1'b1;
          status_d    = kwc_pkg::ST_TOTAL;
          out_key_d   = '0;
          out_value_d = '0;
          total_d     = kwc_pkg::TOTAL_W'(count_q);
          last_d      = 1'b1;
          state_d     = kwc_pkg::S_IDLE;
        end
      end

      kwc_pkg::S_LIST_DAT: begin
        out_valid_d = 1'b1;
        status_d    = kwc_pkg::ST_LISTED;
        out_key_d   = key_rd;
        out_value_d = val_rd;
        total_d     = kwc_pkg::TOTAL_W'(count_q);
        last_d      = 1'b0;
        state_d     = kwc_pkg::S_LIST_WAIT;
      end

      kwc_pkg::S_LIST_WAIT: begin
        if (!out_valid_q) begin
          state_d = kwc_pkg::S_LIST_RD;
        end
      end

      default: state_d = kwc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kwc_pkg::S_IDLE;
      count_q     <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q       <= iss_d;
    chk_idx_q   <= chk_idx_d;
    hit_q       <= hit_d;
    key_q       <= key_d;
    req_q       <= req_d;
    status_q    <= status_d;
    out_key_q   <= out_key_d;
    out_value_q <= out_value_d;
    total_q     <= total_d;
    last_q      <= last_d;
  end

  kwc_ram #(
    .WIDTH(kwc_pkg::DATA_W),
    .DEPTH(kwc_pkg::CAPACITY)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wkey),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(key_rd)
  );

  kwc_ram #(
    .WIDTH(kwc_pkg::DATA_W),
    .DEPTH(kwc_pkg::CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wval),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(val_rd)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = out_key_q;
  assign out_value_o   = out_value_q;
  assign entry_total_o = total_q;
  assign last_o        = last_q;

endmodule

// ----- verif/keyed_table_with_compaction_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table with compaction: self-checking test
// A table of directed requests runs first: empty table, duplicate keys, deletes
// of first, middle and last entries, a full table and a list of it. Random
// segments follow that fill and drain the table. Every result is checked against
// its row's typed result or a behavioral copy of the table kept in this module.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction_core_test;

  localparam int IDLE_LIMIT  = 4000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 300;   // long receiver back-pressure stretch
  localparam int DRAIN_WAIT  = 40;
  localparam int SEGMENTS    = 10;
  localparam int SEG_ITEMS   = 20;
  localparam int PLAN_ROWS   = 22;

  typedef struct packed {
    kwc_pkg::status_e                  status;
    logic [kwc_pkg::DATA_W-1:0]        key;
    logic [kwc_pkg::DATA_W-1:0]        value;
    logic [kwc_pkg::TOTAL_W-1:0]       total;
    logic                              last;
  } table_result_t;

  typedef struct {
    kwc_pkg::req_e                     req;
    logic [kwc_pkg::DATA_W-1:0]        key;
    logic [kwc_pkg::DATA_W-1:0]        value;
    int unsigned                       reps;
    bit                                typed;
    kwc_pkg::status_e                  status;
    logic [kwc_pkg::DATA_W-1:0]        found_value;
    logic [kwc_pkg::TOTAL_W-1:0]       total;
  } plan_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic [kwc_pkg::REQ_W-1:0]           req_type_i;
  logic [kwc_pkg::DATA_W-1:0]          key_i;
  logic [kwc_pkg::DATA_W-1:0]          value_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [kwc_pkg::STAT_W-1:0]          status_o;
  logic [kwc_pkg::DATA_W-1:0]          out_key_o;
  logic [kwc_pkg::DATA_W-1:0]          out_value_o;
  logic [kwc_pkg::TOTAL_W-1:0]         entry_total_o;
  logic                                last_o;

  keyed_table_with_compaction_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_value_o   (out_value_o),
    .entry_total_o (entry_total_o),
    .last_o        (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the table.
  logic [kwc_pkg::DATA_W-1:0] shadow_keys [kwc_pkg::CAPACITY];
  logic [kwc_pkg::DATA_W-1:0] shadow_vals [kwc_pkg::CAPACITY];
  int unsigned                shadow_count = 0;

  table_result_t awaited_results [$];
  table_result_t fresh_results [$];

  int unsigned mismatch_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;
  plan_row_t   plan [PLAN_ROWS];

  function automatic table_result_t make_result(kwc_pkg::status_e st,
                                                logic [kwc_pkg::DATA_W-1:0] k,
                                                logic [kwc_pkg::DATA_W-1:0] v,
                                                logic fin);
    table_result_t r;
    r.status = st;
    r.key    = k;
    r.value  = v;
    r.total  = kwc_pkg::TOTAL_W'(shadow_count);
    r.last   = fin;
    return r;
  endfunction

  // Applies one request to the shadow table and queues the results it yields.
  function automatic void predict_table_results(kwc_pkg::req_e r,
                                                logic [kwc_pkg::DATA_W-1:0] k_in,
                                                logic [kwc_pkg::DATA_W-1:0] v);
    logic [kwc_pkg::DATA_W-1:0] k;
    int hit;
    k = k_in & kwc_pkg::KEY_MASK;
    hit = -1;
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    end
    case (r)
      kwc_pkg::REQ_ADD: begin
        if (shadow_count >= kwc_pkg::CAPACITY) begin
          fresh_results.push_back(make_result(kwc_pkg::ST_FULL, '0, '0, 1'b1));
        end else begin
          shadow_keys[shadow_count] = k;
          shadow_vals[shadow_count] = v;
          shadow_count++;
          fresh_results.push_back(make_result(kwc_pkg::ST_ADDED, '0, '0, 1'b1));
        end
      end
      kwc_pkg::REQ_FIND: begin
        if (hit < 0) begin
          fresh_results.push_back(make_result(kwc_pkg::ST_NOTFOUND, '0, '0, 1'b1));
        end else begin
          fresh_results.push_back(make_result(kwc_pkg::ST_FOUND, '0, shadow_vals[hit],
                                              1'b1));
        end
      end
      kwc_pkg::REQ_DELETE: begin
        if (hit < 0) begin
          fresh_results.push_back(make_result(kwc_pkg::ST_NOTFOUND, '0, '0, 1'b1));
        end else begin
          // The last entry moves into the freed slot.
          shadow_keys[hit] = shadow_keys[shadow_count - 1];
          shadow_vals[hit] = shadow_vals[shadow_count - 1];
          shadow_count--;
          fresh_results.push_back(make_result(kwc_pkg::ST_DELETED, '0, '0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < int'(shadow_count); i++) begin
          fresh_results.push_back(make_result(kwc_pkg::ST_LISTED, shadow_keys[i],
                                              shadow_vals[i], 1'b0));
        end
        fresh_results.push_back(make_result(kwc_pkg::ST_TOTAL, '0, '0, 1'b1));
      end
    endcase
  endfunction

  // Offers one request and waits for it to be taken. Entered and left just
  // after a falling edge.
  task automatic issue_request(kwc_pkg::req_e r, logic [kwc_pkg::DATA_W-1:0] k,
                               logic [kwc_pkg::DATA_W-1:0] v,
                               bit typed, table_result_t typed_res);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r;
    key_i      <= k;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fresh_results.delete();
    predict_table_results(r, k, v);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    @(negedge clk_i);
  endtask

  task automatic random_request(int unsigned add_pct, int unsigned del_pct);
    int unsigned roll;
    kwc_pkg::req_e r;
    logic [kwc_pkg::DATA_W-1:0] k;
    table_result_t none;
    none = '0;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) r = kwc_pkg::REQ_ADD;
    else if (roll < add_pct + del_pct) r = kwc_pkg::REQ_DELETE;
    else if ($urandom_range(0, 2) == 0) r = kwc_pkg::REQ_LIST;
    else r = kwc_pkg::REQ_FIND;
    // Most lookups use a stored key; adds sometimes repeat one.
    if (shadow_count > 0 &&
        $urandom_range(0, 99) < (r == kwc_pkg::REQ_ADD ? 25 : 70))
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    else
      k = {$urandom, $urandom};
    issue_request(r, k, {$urandom, $urandom}, 1'b0, none);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d key %h value %h total %0d last %b",
                   status_o, out_key_o, out_value_o, entry_total_o, last_o);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || out_key_o !== want.key ||
            out_value_o !== want.value || entry_total_o !== want.total ||
            last_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected status %0d key %h value %h ",
                      "total %0d last %b, got status %0d key %h value %h ",
                      "total %0d last %b"},
                     want.status, want.key, want.value, want.total, want.last,
                     status_o, out_key_o, out_value_o, entry_total_o, last_o);
        end
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    table_result_t typed_res;
    int unsigned add_pct;
    int unsigned del_pct;

    in_valid_i = 1'b0;
    req_type_i = kwc_pkg::REQ_ADD;
    key_i      = '0;
    value_i    = '0;
    rst_ni     = 1'b0;

    // Typed rows hold the single result that is obvious from the table state.
    plan = '{
      '{kwc_pkg::REQ_LIST,   '0,    '0,       1, 1'b1, kwc_pkg::ST_TOTAL,    '0, 6'd0},
      '{kwc_pkg::REQ_FIND,   '0,    '0,       1, 1'b1, kwc_pkg::ST_NOTFOUND, '0, 6'd0},
      '{kwc_pkg::REQ_DELETE, 64'h5, '0,       1, 1'b1, kwc_pkg::ST_NOTFOUND, '0, 6'd0},
      '{kwc_pkg::REQ_ADD,    '0,    '1,       1, 1'b1, kwc_pkg::ST_ADDED,    '0, 6'd1},
      '{kwc_pkg::REQ_ADD,    '1,    '0,       1, 1'b1, kwc_pkg::ST_ADDED,    '0, 6'd2},
      '{kwc_pkg::REQ_ADD,    '1,    64'h1234, 1, 1'b1, kwc_pkg::ST_ADDED,    '0, 6'd3},
      '{kwc_pkg::REQ_FIND,   '1,    '0,       1, 1'b1, kwc_pkg::ST_FOUND,    '0, 6'd3},
      '{kwc_pkg::REQ_FIND,   '0,    '0,       1, 1'b1, kwc_pkg::ST_FOUND,    '1, 6'd3},
      '{kwc_pkg::REQ_LIST,   '0,    '0,       1, 1'b0, kwc_pkg::ST_TOTAL,    '0, 6'd0},
      '{kwc_pkg::REQ_DELETE, '1,    '0,       1, 1'b1, kwc_pkg::ST_DELETED,  '0, 6'd2},
      '{kwc_pkg::REQ_FIND,   '1,    '0,       1, 1'b1, kwc_pkg::ST_FOUND,
        64'h1234, 6'd2},
      '{kwc_pkg::REQ_DELETE, '0,    '0,       1, 1'b1, kwc_pkg::ST_DELETED,  '0, 6'd1},
      '{kwc_pkg::REQ_DELETE, '1,    '0,       1, 1'b1, kwc_pkg::ST_DELETED,  '0, 6'd0},
      '{kwc_pkg::REQ_LIST,   '0,    '0,       1, 1'b1, kwc_pkg::ST_TOTAL,    '0, 6'd0},
      // Fill the table with distinct keys, then try one more add.
      '{kwc_pkg::REQ_ADD, 64'hA5A5_0000_0000_0000, 64'h5A5A_0000_0000_0000,
        kwc_pkg::CAPACITY, 1'b0, kwc_pkg::ST_ADDED, '0, 6'd0},
      '{kwc_pkg::REQ_ADD,    64'h1, 64'h2,    1, 1'b1, kwc_pkg::ST_FULL,     '0, 6'd32},
      '{kwc_pkg::REQ_LIST,   '0,    '0,       1, 1'b0, kwc_pkg::ST_TOTAL,    '0, 6'd0},
      '{kwc_pkg::REQ_FIND, 64'hA5A5_0000_0000_001F, '0, 1, 1'b1, kwc_pkg::ST_FOUND,
        64'h5A5A_0000_0000_001F, 6'd32},
      '{kwc_pkg::REQ_DELETE, 64'hA5A5_0000_0000_001F, '0, 1, 1'b1, kwc_pkg::ST_DELETED,
        '0, 6'd31},
      '{kwc_pkg::REQ_DELETE, 64'hA5A5_0000_0000_0000, '0, 1, 1'b1, kwc_pkg::ST_DELETED,
        '0, 6'd30},
      '{kwc_pkg::REQ_FIND, 64'hA5A5_0000_0000_001E, '0, 1, 1'b0, kwc_pkg::ST_FOUND,
        '0, 6'd0},
      '{kwc_pkg::REQ_LIST,   '0,    '0,       1, 1'b0, kwc_pkg::ST_TOTAL,    '0, 6'd0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    foreach (plan[row]) begin
      for (int unsigned rep = 0; rep < plan[row].reps; rep++) begin
        typed_res = '{plan[row].status, '0, plan[row].found_value, plan[row].total, 1'b1};
        issue_request(plan[row].req, plan[row].key + rep, plan[row].value + rep,
                      plan[row].typed, typed_res);
      end
    end

    // Random segments alternate between filling, draining and a mix, so the
    // table swings between empty and full.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 3)
        0:       begin add_pct = 65; del_pct = 10; end
        1:       begin add_pct = 10; del_pct = 60; end
        default: begin add_pct = 35; del_pct = 30; end
      endcase
      if (seg >= SEGMENTS - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 2) * 15;
        stall_pct = $urandom_range(0, 2) * 15;
      end
      if (seg == 2) hold_request = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) random_request(add_pct, del_pct);
    end

    in_valid_i <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- keyed_table_with_compaction_core.f -----
hdl/kwc_pkg.sv
hdl/kwc_ram.sv
hdl/keyed_table_with_compaction_core.sv
verif/keyed_table_with_compaction_core_test.sv
